// ===== sv/pulse_width_serial_frame_receiver_defines.svh =====
// Assertion macros used by the receiver controller (pwsfr_rx_ctrl).
// Build with NO_ASSERTIONS defined to compile them out.
`ifndef PULSE_WIDTH_SERIAL_FRAME_RECEIVER_DEFINES_SVH
`define PULSE_WIDTH_SERIAL_FRAME_RECEIVER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during reset.
`define PWSFR_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pwsfr assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define PWSFR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pwsfr assertion failed");
`else
`define PWSFR_ASSERT_IMPL(lbl, ante, cons)
`define PWSFR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/pwsfr_pkg.sv =====
`default_nettype none
package pwsfr_pkg;

	// Request codes on req_type.
	localparam logic [1:0] REQ_PULSE   = 2'd0;
	localparam logic [1:0] REQ_TIMEOUT = 2'd1;
	localparam logic [1:0] REQ_READ    = 2'd2;
	localparam logic [1:0] REQ_CLEAR   = 2'd3;

	localparam int unsigned FRAME_BYTES_DEF = 64;
	localparam logic [7:0]  THRESH_RESET    = 8'd128;

	localparam int unsigned REQ_W   = 2;
	localparam int unsigned WIDTH_W = 8;
	localparam int unsigned INDEX_W = 6;
	localparam int unsigned LEN_W   = 7;
	localparam int unsigned BYTE_W  = 8;

endpackage
`default_nettype wire

// ===== sv/pwsfr_ifs.sv =====
`default_nettype none
// Input channel: one request beat.
interface pwsfr_in_if
	import pwsfr_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [REQ_W-1:0]   req_type;
	logic [WIDTH_W-1:0] pulse_width;
	logic [INDEX_W-1:0] read_index;

	modport source (output valid, output req_type, output pulse_width, output read_index,
		input ready);
	modport sink (input valid, input req_type, input pulse_width, input read_index,
		output ready);
endinterface

// Output channel: one result beat.
interface pwsfr_out_if
	import pwsfr_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              frame_ready;
	logic [LEN_W-1:0]  frame_length;
	logic [BYTE_W-1:0] read_data;
	logic              overflow;

	modport source (output valid, output frame_ready, output frame_length,
		output read_data, output overflow, input ready);
	modport sink (input valid, input frame_ready, input frame_length,
		input read_data, input overflow, output ready);
endinterface
`default_nettype wire

// ===== sv/pwsfr_frame_mem.sv =====
`default_nettype none
module pwsfr_frame_mem
	import pwsfr_pkg::*;
#(
	parameter int unsigned DEPTH = FRAME_BYTES_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [BYTE_W-1:0]        wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [BYTE_W-1:0]        rdata
);

	logic [BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; data holds while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/pwsfr_rx_ctrl.sv =====
`default_nettype none
`include "pulse_width_serial_frame_receiver_defines.svh"
module pwsfr_rx_ctrl
	import pwsfr_pkg::*;
#(
	parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [WIDTH_W-1:0]             bit_threshold,
	pwsfr_in_if.sink                            in_ch,
	pwsfr_out_if.source                         out_ch,
	output logic                                mem_we,
	output logic [$clog2(FRAME_BYTES)-1:0]      mem_waddr,
	output logic [BYTE_W-1:0]                   mem_wdata,
	output logic                                mem_re,
	output logic [$clog2(FRAME_BYTES)-1:0]      mem_raddr,
	input  wire logic [BYTE_W-1:0]              mem_rdata
);

	localparam int unsigned AW = $clog2(FRAME_BYTES);
	localparam int unsigned CW = $clog2(FRAME_BYTES + 1);
	localparam int unsigned XW = (CW > INDEX_W) ? CW : INDEX_W;
	localparam logic [CW-1:0] CAP = CW'(FRAME_BYTES);

	// Receive state.
	logic [BYTE_W-1:0] shift_q;
	logic [2:0]        bits_q;
	logic [CW-1:0]     bytes_q;
	logic              ready_q;
	logic              ovf_q;

	logic [BYTE_W-1:0] shift_n;
	logic [2:0]        bits_n;
	logic [CW-1:0]     bytes_n;
	logic              ready_n;
	logic              ovf_n;

	// Result register.
	logic              ovalid_q;
	logic              res_ready_q;
	logic [LEN_W-1:0]  res_len_q;
	logic              res_ovf_q;
	logic              res_sel_q;

	logic              accept;
	logic              bit_val;
	logic [CW-1:0]     len_n;
	logic [XW-1:0]     idx_x;
	logic              rd_hit;

	assign in_ch.ready = !ovalid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;
	assign bit_val     = in_ch.pulse_width < bit_threshold;

	always_comb begin
		shift_n   = shift_q;
		bits_n    = bits_q;
		bytes_n   = bytes_q;
		ready_n   = ready_q;
		ovf_n     = ovf_q;
		mem_we    = 1'b0;
		mem_waddr = bytes_q[AW-1:0];
		mem_wdata = {shift_q[BYTE_W-2:0], bit_val};
		unique case (in_ch.req_type)
			REQ_PULSE: begin
				ready_n = 1'b0;
				if (bits_q == 3'd7) begin
					// Byte complete: store it, or drop it when the buffer is full.
					if (bytes_q < CAP) begin
						mem_we  = accept;
						bytes_n = bytes_q + CW'(1);
					end else begin
						ovf_n = 1'b1;
					end
					shift_n = '0;
					bits_n  = '0;
				end else begin
					shift_n = {shift_q[BYTE_W-2:0], bit_val};
					bits_n  = bits_q + 3'd1;
				end
			end
			REQ_TIMEOUT: begin
				if (bytes_q != '0) begin
					ready_n = 1'b1;
				end else begin
					shift_n = '0;
					bits_n  = '0;
					bytes_n = '0;
					ready_n = 1'b0;
					ovf_n   = 1'b0;
				end
			end
			REQ_CLEAR: begin
				shift_n = '0;
				bits_n  = '0;
				bytes_n = '0;
				ready_n = 1'b0;
				ovf_n   = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign len_n     = ready_n ? bytes_n : '0;
	assign idx_x     = XW'(in_ch.read_index);
	assign rd_hit    = (in_ch.req_type == REQ_READ) && ready_n && (idx_x < XW'(len_n));
	assign mem_re    = accept && rd_hit;
	assign mem_raddr = idx_x[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= '0;
			bits_q   <= '0;
			bytes_q  <= '0;
			ready_q  <= 1'b0;
			ovf_q    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (accept) begin
				shift_q <= shift_n;
				bits_q  <= bits_n;
				bytes_q <= bytes_n;
				ready_q <= ready_n;
				ovf_q   <= ovf_n;
			end
			if (accept) begin
				ovalid_q <= 1'b1;
			end else if (out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_ready_q <= ready_n;
			res_len_q   <= LEN_W'(len_n);
			res_ovf_q   <= ovf_n;
			res_sel_q   <= rd_hit;
		end
	end

	assign out_ch.valid        = ovalid_q;
	assign out_ch.frame_ready  = res_ready_q;
	assign out_ch.frame_length = res_len_q;
	assign out_ch.overflow     = res_ovf_q;
	assign out_ch.read_data    = res_sel_q ? mem_rdata : '0;

	`PWSFR_ASSERT_IMPL(a_ready_has_bytes, ready_q, bytes_q != '0)
	`PWSFR_ASSERT_IMPL(a_write_in_range, mem_we, bytes_q < CAP)
	`PWSFR_ASSERT_NEXT(a_clear_empties, accept && in_ch.req_type == REQ_CLEAR,
		bytes_q == '0 && !ovf_q && !ready_q)
	`PWSFR_ASSERT_IMPL(a_data_needs_frame, out_ch.valid && out_ch.read_data != '0,
		out_ch.frame_ready)

endmodule
`default_nettype wire

// ===== sv/pulse_width_serial_frame_receiver.sv =====
// Each result beat is registered: it appears in the cycle after its request beat is accepted.
// Throughput: one request per cycle while the result side keeps up; a result
// beat waiting in the single result register holds the input off.
// Reset (arst_n low): receive state cleared, threshold back to 128, no result
// pending; the frame buffer is not cleared, reads only reach stored bytes.
`default_nettype none
module pulse_width_serial_frame_receiver
	import pwsfr_pkg::*;
#(
	parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	pwsfr_in_if.sink                in_ch,
	pwsfr_out_if.source             out_ch,
	input  wire logic               cfg_we,
	input  wire logic [WIDTH_W-1:0] cfg_wdata
);

	localparam int unsigned AW = $clog2(FRAME_BYTES);

	// Bit threshold register: pulses shorter than this decode as one.
	logic [WIDTH_W-1:0] thresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_we) begin
			thresh_q <= cfg_wdata;
		end
	end

	// Frame buffer port signals. The controller writes a completed byte
	// and issues a read for a read request, both only at the accept edge,
	// so one beat never sees a write and a read of the same entry at once;
	// a read beat sees every byte stored by earlier beats.
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [BYTE_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [BYTE_W-1:0] mem_rdata;

	// Controller: bit decode, byte assembly, frame flags and the result
	// register that parts the input side from the output side.
	pwsfr_rx_ctrl #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.bit_threshold (thresh_q),
		.in_ch         (in_ch),
		.out_ch        (out_ch),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_re        (mem_re),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata)
	);

	// Frame buffer: one byte per entry, registered read data held until
	// the next read, which is how a stalled result keeps its byte.
	pwsfr_frame_mem #(
		.DEPTH (FRAME_BYTES)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
`default_nettype wire
